// ===== hw/rtl/register_alu_compare_branch_top_assert.svh =====
// Assertion macros shared by the register ALU modules.
`ifndef REGISTER_ALU_COMPARE_BRANCH_TOP_ASSERT_SVH
`define REGISTER_ALU_COMPARE_BRANCH_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RAC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("register alu: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("register alu: next-cycle check failed");

`endif

// ===== hw/rtl/rac_pkg.sv =====
// Shared types, codes and widths for the register ALU.
package rac_pkg;

   localparam int DEF_NUM_REGS   = 8;
   localparam int DEF_ADDR_WIDTH = 16;

   localparam int DATA_W       = 32;
   localparam int MODE_W       = 5;
   localparam int REG_FIELD_W  = 3;
   localparam int ADDR_FIELD_W = 16;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 56;

   localparam int QUEUE_DEPTH = 2;

   localparam int MUL_STEP_W = 8;
   localparam int MUL_STEPS  = DATA_W / MUL_STEP_W;
   localparam int DIV_STEPS  = DATA_W;

   localparam logic [MODE_W-1:0] MODE_MOV   = 5'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 5'd1;
   localparam logic [MODE_W-1:0] MODE_SUB   = 5'd2;
   localparam logic [MODE_W-1:0] MODE_MUL   = 5'd3;
   localparam logic [MODE_W-1:0] MODE_DIV   = 5'd4;
   localparam logic [MODE_W-1:0] MODE_AND   = 5'd5;
   localparam logic [MODE_W-1:0] MODE_OR    = 5'd6;
   localparam logic [MODE_W-1:0] MODE_NOT   = 5'd7;
   localparam logic [MODE_W-1:0] MODE_INC   = 5'd8;
   localparam logic [MODE_W-1:0] MODE_DEC   = 5'd9;
   localparam logic [MODE_W-1:0] MODE_CMP   = 5'd10;
   localparam logic [MODE_W-1:0] MODE_JE    = 5'd11;
   localparam logic [MODE_W-1:0] MODE_JG    = 5'd12;
   localparam logic [MODE_W-1:0] MODE_JGE   = 5'd13;
   localparam logic [MODE_W-1:0] MODE_JLE   = 5'd14;
   localparam logic [MODE_W-1:0] MODE_JL    = 5'd15;
   localparam logic [MODE_W-1:0] MODE_JMP   = 5'd16;
   localparam logic [MODE_W-1:0] MODE_PRINT = 5'd17;

   // OP_READ covers print and every undefined mode: nothing changes.
   typedef enum logic [4:0] {
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_NOT,
      OP_INC, OP_DEC, OP_CMP, OP_JE, OP_JG, OP_JGE, OP_JLE, OP_JL,
      OP_JMP, OP_READ
   } rac_op_type;

   typedef struct packed {
      rac_op_type               op;
      logic [REG_FIELD_W-1:0]   dest_reg;
      logic                     src_is_reg;
      logic [REG_FIELD_W-1:0]   src_reg;
      logic [DATA_W-1:0]        immediate;
      logic [ADDR_FIELD_W-1:0]  jump_target;
      logic                     target_known;
   } rac_item_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } rac_md_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rac_md_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_EXEC, ST_MULDIV, ST_RESP
   } rac_state_type;

endpackage

// ===== hw/rtl/register_alu_compare_branch_top.sv =====
// Top level of the two-operand register ALU with compare flag and branches.
// One instruction is executed at a time. The front end registers and decodes
// each request and places it in a two-entry queue; the back end sequencer then
// reads the register file, executes and writes back. A simple instruction (mov,
// add, logic ops, cmp, jumps, print) goes through the execute and write-back
// steps of the sequencer. mul runs four 8-bit steps of the shared multiply/divide
// unit, div runs that unit at one quotient bit per cycle; a division by zero skips
// the unit and sets div_error. A response is held in an output register until
// taken.
module register_alu_compare_branch_top #(
   parameter int NUM_REGS   = rac_pkg::DEF_NUM_REGS,
   parameter int ADDR_WIDTH = rac_pkg::DEF_ADDR_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode[4:0], dest_reg[7:5], src_reg[10:8], immediate[42:11],
   // jump_target[58:43], target_known[59], zero[63:60]
   input  logic [rac_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // src_is_reg[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // value[31:0], jump_taken[32], next_address[48:33], div_error[49], zero[55:50]
   output logic [rac_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import rac_pkg::*;

   localparam int RSP_PAD_W = RSP_TDATA_W - (DATA_W + 1 + ADDR_FIELD_W + 1);

   logic                     push_valid, push_ready;
   rac_item_type             push_item;
   logic                     pop_valid, pop_en;
   rac_item_type             pop_item;
   rac_md_ctrl_type          md_ctrl;
   rac_md_stat_type          md_stat;
   logic [DATA_W-1:0]        md_a, md_b, md_result;
   logic [DATA_W-1:0]        rsp_value;
   logic                     rsp_jump_taken, rsp_div_error;
   logic [ADDR_FIELD_W-1:0]  rsp_next_address;

   rac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   rac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_en     (pop_en),
      .pop_item   (pop_item)
   );

   rac_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .opa    (md_a),
      .opb    (md_b),
      .stat   (md_stat),
      .result (md_result)
   );

   rac_back #(
      .NUM_REGS   (NUM_REGS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_en           (pop_en),
      .pop_item         (pop_item),
      .md_ctrl          (md_ctrl),
      .md_a             (md_a),
      .md_b             (md_b),
      .md_stat          (md_stat),
      .md_result        (md_result),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_value        (rsp_value),
      .rsp_jump_taken   (rsp_jump_taken),
      .rsp_next_address (rsp_next_address),
      .rsp_div_error    (rsp_div_error)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_div_error, rsp_next_address,
                       rsp_jump_taken, rsp_value};

endmodule

// ===== hw/rtl/rac_front.sv =====
// Front end: takes requests, decodes the mode and holds one decoded instruction.
module rac_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode[4:0], dest_reg[7:5], src_reg[10:8], immediate[42:11],
   // jump_target[58:43], target_known[59], zero[63:60]
   input  logic [rac_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // src_is_reg[0]
   input  logic                              req_tuser,
   output logic                              push_valid,
   input  logic                              push_ready,
   output rac_pkg::rac_item_type             push_item
);
   import rac_pkg::*;

   localparam int MODE_LSB  = 0;
   localparam int DEST_LSB  = MODE_LSB + MODE_W;
   localparam int SRC_LSB   = DEST_LSB + REG_FIELD_W;
   localparam int IMM_LSB   = SRC_LSB + REG_FIELD_W;
   localparam int TGT_LSB   = IMM_LSB + DATA_W;
   localparam int KNOWN_BIT = TGT_LSB + ADDR_FIELD_W;

   logic              front_valid_ff;
   rac_item_type      front_item_ff;
   rac_item_type      front_item_in;
   logic [MODE_W-1:0] mode;
   logic              accept;

   assign req_tready = !front_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign mode       = req_tdata[MODE_LSB +: MODE_W];

   always_comb begin
      front_item_in.dest_reg     = req_tdata[DEST_LSB +: REG_FIELD_W];
      front_item_in.src_is_reg   = req_tuser;
      front_item_in.src_reg      = req_tdata[SRC_LSB +: REG_FIELD_W];
      front_item_in.immediate    = req_tdata[IMM_LSB +: DATA_W];
      front_item_in.jump_target  = req_tdata[TGT_LSB +: ADDR_FIELD_W];
      front_item_in.target_known = req_tdata[KNOWN_BIT];
      unique case (mode)
         MODE_MOV:   front_item_in.op = OP_MOV;
         MODE_ADD:   front_item_in.op = OP_ADD;
         MODE_SUB:   front_item_in.op = OP_SUB;
         MODE_MUL:   front_item_in.op = OP_MUL;
         MODE_DIV:   front_item_in.op = OP_DIV;
         MODE_AND:   front_item_in.op = OP_AND;
         MODE_OR:    front_item_in.op = OP_OR;
         MODE_NOT:   front_item_in.op = OP_NOT;
         MODE_INC:   front_item_in.op = OP_INC;
         MODE_DEC:   front_item_in.op = OP_DEC;
         MODE_CMP:   front_item_in.op = OP_CMP;
         MODE_JE:    front_item_in.op = OP_JE;
         MODE_JG:    front_item_in.op = OP_JG;
         MODE_JGE:   front_item_in.op = OP_JGE;
         MODE_JLE:   front_item_in.op = OP_JLE;
         MODE_JL:    front_item_in.op = OP_JL;
         MODE_JMP:   front_item_in.op = OP_JMP;
         MODE_PRINT: front_item_in.op = OP_READ;
         default:    front_item_in.op = OP_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (accept) begin
         front_valid_ff <= 1'b1;
      end else if (push_ready) begin
         front_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

endmodule

// ===== hw/rtl/rac_queue.sv =====
// Short instruction queue between the front end and the execution back end.
module rac_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rac_pkg::rac_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_en,
   output rac_pkg::rac_item_type pop_item
);
   import rac_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rac_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_en;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_en    = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/rac_muldiv.sv =====
`include "register_alu_compare_branch_top_assert.svh"
// Shared iterative unit: 8-bit-per-step multiply, 1-bit-per-step signed divide.
module rac_muldiv (
   input  logic                        clock,
   input  logic                        reset,
   input  rac_pkg::rac_md_ctrl_type    ctrl,
   input  logic [rac_pkg::DATA_W-1:0]  opa,
   input  logic [rac_pkg::DATA_W-1:0]  opb,
   output rac_pkg::rac_md_stat_type    stat,
   output logic [rac_pkg::DATA_W-1:0]  result
);
   import rac_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic                         busy_ff, done_ff, is_div_ff, neg_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [DATA_W:0]              work_ff, work_in;
   logic [DATA_W-1:0]            shift_ff, shift_in;
   logic [DATA_W-1:0]            oper_ff, oper_in;
   logic [DATA_W+MUL_STEP_W-1:0] partial;
   logic [DATA_W:0]              rem_shift, rem_diff;
   logic [DATA_W-1:0]            mag_a, mag_b;

   assign mag_a = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
   assign mag_b = opb[DATA_W-1] ? (~opb + 1'b1) : opb;

   // work holds the product (multiply) or the partial remainder (divide);
   // shift holds the multiplier bytes or the dividend turning into the quotient
   always_comb begin
      partial   = oper_ff * shift_ff[MUL_STEP_W-1:0];
      rem_shift = {work_ff[DATA_W-1:0], shift_ff[DATA_W-1]};
      rem_diff  = rem_shift - {1'b0, oper_ff};
      if (is_div_ff) begin
         oper_in = oper_ff;
         if (!rem_diff[DATA_W]) begin
            work_in  = rem_diff;
            shift_in = {shift_ff[DATA_W-2:0], 1'b1};
         end else begin
            work_in  = rem_shift;
            shift_in = {shift_ff[DATA_W-2:0], 1'b0};
         end
      end else begin
         work_in  = {1'b0, work_ff[DATA_W-1:0] + partial[DATA_W-1:0]};
         shift_in = shift_ff >> MUL_STEP_W;
         oper_in  = oper_ff << MUL_STEP_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == '0);
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= ctrl.is_div ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         is_div_ff <= ctrl.is_div;
         neg_ff    <= opa[DATA_W-1] ^ opb[DATA_W-1];
         work_ff   <= '0;
         shift_ff  <= ctrl.is_div ? mag_a : opb;
         oper_ff   <= ctrl.is_div ? mag_b : opa;
      end else if (busy_ff) begin
         work_ff  <= work_in;
         shift_ff <= shift_in;
         oper_ff  <= oper_in;
      end
   end

   // most negative over minus one wraps back to most negative here
   assign result = is_div_ff ? (neg_ff ? (~shift_ff + 1'b1) : shift_ff)
                             : work_ff[DATA_W-1:0];

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `RAC_ASSERT_SAME(a_md_start_when_free, clock, reset, ctrl.start, !busy_ff && !done_ff)
   `RAC_ASSERT_NEXT(a_md_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

// ===== hw/rtl/rac_back.sv =====
`include "register_alu_compare_branch_top_assert.svh"
// Back end: register file, compare flag, execute sequencer and response register.
module rac_back #(
   parameter int NUM_REGS   = rac_pkg::DEF_NUM_REGS,
   parameter int ADDR_WIDTH = rac_pkg::DEF_ADDR_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_en,
   input  rac_pkg::rac_item_type             pop_item,
   output rac_pkg::rac_md_ctrl_type          md_ctrl,
   output logic [rac_pkg::DATA_W-1:0]        md_a,
   output logic [rac_pkg::DATA_W-1:0]        md_b,
   input  rac_pkg::rac_md_stat_type          md_stat,
   input  logic [rac_pkg::DATA_W-1:0]        md_result,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rac_pkg::DATA_W-1:0]        rsp_value,
   output logic                              rsp_jump_taken,
   output logic [rac_pkg::ADDR_FIELD_W-1:0]  rsp_next_address,
   output logic                              rsp_div_error
);
   import rac_pkg::*;

   localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MASK_W = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
   localparam logic [ADDR_FIELD_W-1:0] ADDR_MASK =
      ADDR_FIELD_W'((64'd1 << MASK_W) - 64'd1);

   rac_state_type           state_ff, state_in;
   rac_item_type            cur_ff;

   logic [DATA_W-1:0]       mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0]     valid_ff;
   logic [DATA_W-1:0]       rda_ff, rdb_ff, byp_ff;
   logic                    a_ok_ff, b_ok_ff, a_hit_ff, b_hit_ff;
   logic [IDX_W-1:0]        rda_addr, rdb_addr, wr_addr;
   logic                    rda_range, rdb_range;
   logic                    wr_en;

   logic [DATA_W-1:0]       cmp_ff, cmp_in;
   logic [DATA_W-1:0]       res_ff, res_in;
   logic                    wb_ff, wb_in;
   logic                    taken_ff, taken_in;
   logic                    derr_ff, derr_in;
   logic                    dok_ff, dok_in;
   logic                    need_md, md_div;
   logic                    is_jump, cond;
   logic                    cmp_zero, cmp_neg;
   logic [DATA_W-1:0]       opa, opb, reg_b;

   logic                    out_free, rsp_load;
   logic                    rsp_valid_ff;
   logic [DATA_W-1:0]       rsp_value_ff;
   logic                    rsp_taken_ff, rsp_derr_ff;
   logic [ADDR_FIELD_W-1:0] rsp_next_ff;

   // register file read, issued as the instruction leaves the queue
   assign rda_addr  = IDX_W'(pop_item.dest_reg);
   assign rdb_addr  = IDX_W'(pop_item.src_reg);
   assign rda_range = 32'(pop_item.dest_reg) < 32'(NUM_REGS);
   assign rdb_range = 32'(pop_item.src_reg) < 32'(NUM_REGS);
   assign wr_addr   = IDX_W'(cur_ff.dest_reg);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= res_ff;
      end
      rda_ff <= mem_ff[rda_addr];
      rdb_ff <= mem_ff[rdb_addr];
   end

   // forward a write-back that lands on the same edge as the read
   always_ff @(posedge clock) begin
      a_ok_ff  <= rda_range && valid_ff[rda_addr];
      b_ok_ff  <= rdb_range && valid_ff[rdb_addr];
      a_hit_ff <= rda_range && wr_en && (wr_addr == rda_addr);
      b_hit_ff <= rdb_range && wr_en && (wr_addr == rdb_addr);
      byp_ff   <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign opa   = a_hit_ff ? byp_ff : (a_ok_ff ? rda_ff : '0);
   assign reg_b = b_hit_ff ? byp_ff : (b_ok_ff ? rdb_ff : '0);
   assign opb   = cur_ff.src_is_reg ? reg_b : cur_ff.immediate;
   assign md_a  = opa;
   assign md_b  = opb;

   assign cmp_zero = cmp_ff == '0;
   assign cmp_neg  = cmp_ff[DATA_W-1];

   // execute: everything but multiply and divide settles here
   always_comb begin
      res_in  = opa;
      wb_in   = 1'b0;
      derr_in = 1'b0;
      cmp_in  = cmp_ff;
      need_md = 1'b0;
      md_div  = 1'b0;
      is_jump = 1'b0;
      cond    = 1'b0;
      unique case (cur_ff.op)
         OP_MOV: begin
            res_in = opb;
            wb_in  = 1'b1;
         end
         OP_ADD: begin
            res_in = opa + opb;
            wb_in  = 1'b1;
         end
         OP_SUB: begin
            res_in = opa - opb;
            wb_in  = 1'b1;
         end
         OP_MUL: begin
            need_md = 1'b1;
            wb_in   = 1'b1;
         end
         OP_DIV: begin
            if (opb == '0) begin
               derr_in = 1'b1;
            end else begin
               need_md = 1'b1;
               md_div  = 1'b1;
               wb_in   = 1'b1;
            end
         end
         OP_AND: begin
            res_in = opa & opb;
            wb_in  = 1'b1;
         end
         OP_OR: begin
            res_in = opa | opb;
            wb_in  = 1'b1;
         end
         OP_NOT: begin
            res_in = ~opa;
            wb_in  = 1'b1;
         end
         OP_INC: begin
            res_in = opa + 1'b1;
            wb_in  = 1'b1;
         end
         OP_DEC: begin
            res_in = opa - 1'b1;
            wb_in  = 1'b1;
         end
         OP_CMP: cmp_in = opa - opb;
         OP_JE: begin
            is_jump = 1'b1;
            cond    = cmp_zero;
         end
         OP_JG: begin
            is_jump = 1'b1;
            cond    = !cmp_neg && !cmp_zero;
         end
         OP_JGE: begin
            is_jump = 1'b1;
            cond    = !cmp_neg;
         end
         OP_JLE: begin
            is_jump = 1'b1;
            cond    = cmp_neg || cmp_zero;
         end
         OP_JL: begin
            is_jump = 1'b1;
            cond    = cmp_neg;
         end
         OP_JMP: begin
            is_jump = 1'b1;
            cond    = 1'b1;
         end
         OP_READ: begin
         end
         default: begin
         end
      endcase
      taken_in = is_jump && cond && cur_ff.target_known;
      dok_in   = 32'(cur_ff.dest_reg) < 32'(NUM_REGS);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (pop_valid) state_in = ST_EXEC;
         ST_EXEC:   state_in = need_md ? ST_MULDIV : ST_RESP;
         ST_MULDIV: if (md_stat.done) state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = pop_valid ? ST_EXEC : ST_IDLE;
            end
         end
      endcase
   end

   // sequencer: outputs
   always_comb begin
      pop_en         = 1'b0;
      rsp_load       = 1'b0;
      md_ctrl.start  = 1'b0;
      md_ctrl.is_div = 1'b0;
      unique case (state_ff)
         ST_IDLE: pop_en = pop_valid;
         ST_EXEC: begin
            md_ctrl.start  = need_md;
            md_ctrl.is_div = md_div;
         end
         ST_MULDIV: begin
         end
         ST_RESP: begin
            rsp_load = out_free;
            pop_en   = out_free && pop_valid;
         end
      endcase
   end

   assign wr_en = rsp_load && wb_ff && dok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EXEC) begin
            cmp_ff <= cmp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_en) begin
         cur_ff <= pop_item;
      end
      if (state_ff == ST_EXEC) begin
         res_ff   <= res_in;
         wb_ff    <= wb_in;
         taken_ff <= taken_in;
         derr_ff  <= derr_in;
         dok_ff   <= dok_in;
      end else if (state_ff == ST_MULDIV && md_stat.done) begin
         res_ff <= md_result;
      end
   end

   // response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= dok_ff ? res_ff : '0;
         rsp_taken_ff <= taken_ff;
         rsp_next_ff  <= taken_ff ? (cur_ff.jump_target & ADDR_MASK) : '0;
         rsp_derr_ff  <= derr_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_jump_taken   = rsp_taken_ff;
   assign rsp_next_address = rsp_next_ff;
   assign rsp_div_error    = rsp_derr_ff;

   `RAC_ASSERT_SAME(a_div_nonzero, clock, reset, md_ctrl.start && md_ctrl.is_div, md_b != '0)
   `RAC_ASSERT_SAME(a_md_running, clock, reset, state_ff == ST_MULDIV, md_stat.busy || md_stat.done)
   `RAC_ASSERT_SAME(a_next_masked, clock, reset, rsp_valid_ff, (rsp_next_ff & ~ADDR_MASK) == '0)

endmodule

// ===== sim/register_alu_compare_branch_top_tb.sv =====
// Self-checking testbench for the register ALU: directed table, then randomised traffic.
module register_alu_compare_branch_top_tb;
   import rac_pkg::*;

   localparam int NUM_DIRECTED  = 25;
   localparam int RANDOM_PER_PH = 440;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic [REG_FIELD_W-1:0]  dest_reg;
      logic                    src_is_reg;
      logic [REG_FIELD_W-1:0]  src_reg;
      logic [DATA_W-1:0]       immediate;
      logic [ADDR_FIELD_W-1:0] jump_target;
      logic                    target_known;
   } instr_type;

   typedef struct {
      logic [DATA_W-1:0]       value;
      logic                    jump_taken;
      logic [ADDR_FIELD_W-1:0] next_address;
      logic                    div_error;
   } outcome_type;

   typedef struct {
      instr_type         instr;
      logic              fixed;
      logic [DATA_W-1:0] fixed_value;
      logic              fixed_div_error;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [DATA_W-1:0] reg_shadow [DEF_NUM_REGS];
   logic [DATA_W-1:0] flag_shadow;
   outcome_type       pending_outcomes [$];
   int                error_count = 0;
   int                sender_idle_pct = 0;
   int                rsp_stall_pct = 0;

   // Rows with fixed = 1 carry a hand-worked result; jumps are never among them.
   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{MODE_PRINT, 3'd3, 1'b1, 3'd5, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'h0000_0000, 1'b0},
      '{'{MODE_MOV,   3'd0, 1'b0, 3'd0, 32'h7FFF_FFFF, 16'h0000, 1'b0}, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{'{MODE_MOV,   3'd1, 1'b0, 3'd0, 32'h8000_0000, 16'h0000, 1'b0}, 1'b1, 32'h8000_0000, 1'b0},
      '{'{MODE_ADD,   3'd0, 1'b0, 3'd0, 32'h0000_0001, 16'h0000, 1'b0}, 1'b1, 32'h8000_0000, 1'b0},
      '{'{MODE_SUB,   3'd1, 1'b0, 3'd0, 32'h0000_0001, 16'h0000, 1'b0}, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{'{MODE_MOV,   3'd2, 1'b0, 3'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0}, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{'{MODE_MUL,   3'd2, 1'b1, 3'd2, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_DIV,   3'd1, 1'b0, 3'd0, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{'{MODE_MOV,   3'd3, 1'b1, 3'd0, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_DIV,   3'd3, 1'b0, 3'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0}, 1'b1, 32'h8000_0000, 1'b0},
      '{'{MODE_DIV,   3'd0, 1'b0, 3'd0, 32'hFFFF_FFF9, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_DIV,   3'd4, 1'b1, 3'd7, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'h0000_0000, 1'b1},
      '{'{MODE_AND,   3'd2, 1'b1, 3'd1, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_OR,    3'd4, 1'b0, 3'd0, 32'hA5A5_A5A5, 16'h0000, 1'b0}, 1'b1, 32'hA5A5_A5A5, 1'b0},
      '{'{MODE_NOT,   3'd4, 1'b0, 3'd0, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_INC,   3'd5, 1'b0, 3'd0, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'h0000_0001, 1'b0},
      '{'{MODE_DEC,   3'd6, 1'b0, 3'd0, 32'h0000_0000, 16'h0000, 1'b0}, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{'{MODE_CMP,   3'd5, 1'b0, 3'd0, 32'h0000_0001, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_JE,    3'd0, 1'b0, 3'd0, 32'h0000_0000, 16'hFFFF, 1'b1}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_JG,    3'd1, 1'b0, 3'd0, 32'h0000_0000, 16'h1234, 1'b1}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_CMP,   3'd6, 1'b0, 3'd0, 32'h0000_0000, 16'h0000, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_JLE,   3'd2, 1'b0, 3'd0, 32'h0000_0000, 16'h0000, 1'b1}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_JL,    3'd3, 1'b0, 3'd0, 32'h0000_0000, 16'hFFFF, 1'b0}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_JGE,   3'd4, 1'b0, 3'd0, 32'h0000_0000, 16'hFFFF, 1'b1}, 1'b0, 32'h0, 1'b0},
      '{'{MODE_JMP,   3'd7, 1'b1, 3'd7, 32'h0000_0000, 16'hFFFF, 1'b1}, 1'b0, 32'h0, 1'b0}
   };

   register_alu_compare_branch_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Signed division on magnitudes, truncating towards zero; most negative / -1 wraps.
   function automatic logic [DATA_W-1:0] signed_quotient(logic [DATA_W-1:0] a,
                                                         logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] ma;
      logic [DATA_W-1:0] mb;
      logic [DATA_W-1:0] q;
      ma = a[DATA_W-1] ? (32'd0 - a) : a;
      mb = b[DATA_W-1] ? (32'd0 - b) : b;
      q  = ma / mb;
      return (a[DATA_W-1] != b[DATA_W-1]) ? (32'd0 - q) : q;
   endfunction

   // Execute one instruction on the shadow registers and return its outcome.
   function automatic outcome_type execute_alu(instr_type i);
      outcome_type       o;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              neg;
      logic              zero;
      logic              cond;
      logic              is_jump;
      a       = reg_shadow[i.dest_reg];
      b       = i.src_is_reg ? reg_shadow[i.src_reg] : i.immediate;
      neg     = flag_shadow[DATA_W-1];
      zero    = (flag_shadow == '0);
      cond    = 1'b0;
      is_jump = 1'b0;
      o       = '{default: '0};
      case (i.mode)
         MODE_MOV: reg_shadow[i.dest_reg] = b;
         MODE_ADD: reg_shadow[i.dest_reg] = a + b;
         MODE_SUB: reg_shadow[i.dest_reg] = a - b;
         MODE_MUL: reg_shadow[i.dest_reg] = a * b;
         MODE_DIV: begin
            if (b == '0) o.div_error = 1'b1;
            else reg_shadow[i.dest_reg] = signed_quotient(a, b);
         end
         MODE_AND: reg_shadow[i.dest_reg] = a & b;
         MODE_OR:  reg_shadow[i.dest_reg] = a | b;
         MODE_NOT: reg_shadow[i.dest_reg] = ~a;
         MODE_INC: reg_shadow[i.dest_reg] = a + 32'd1;
         MODE_DEC: reg_shadow[i.dest_reg] = a - 32'd1;
         MODE_CMP: flag_shadow = a - b;
         MODE_JE:  begin is_jump = 1'b1; cond = zero; end
         MODE_JG:  begin is_jump = 1'b1; cond = !neg && !zero; end
         MODE_JGE: begin is_jump = 1'b1; cond = !neg; end
         MODE_JLE: begin is_jump = 1'b1; cond = neg || zero; end
         MODE_JL:  begin is_jump = 1'b1; cond = neg; end
         MODE_JMP: begin is_jump = 1'b1; cond = 1'b1; end
         default: ;
      endcase
      o.value        = reg_shadow[i.dest_reg];
      o.jump_taken   = is_jump && cond && i.target_known;
      o.next_address = o.jump_taken ? i.jump_target : '0;
      return o;
   endfunction

   function automatic instr_type random_instr();
      instr_type i;
      i.mode       = MODE_W'($urandom_range(MODE_PRINT, MODE_MOV));
      i.dest_reg   = REG_FIELD_W'($urandom_range(DEF_NUM_REGS - 1));
      i.src_is_reg = 1'($urandom_range(1));
      i.src_reg    = REG_FIELD_W'($urandom_range(DEF_NUM_REGS - 1));
      case ($urandom_range(7))
         0:       i.immediate = 32'h0000_0000;
         1:       i.immediate = 32'h0000_0001;
         2:       i.immediate = 32'hFFFF_FFFF;
         3:       i.immediate = 32'h8000_0000;
         4:       i.immediate = 32'h7FFF_FFFF;
         5:       i.immediate = $urandom_range(15) - 8;
         default: i.immediate = $urandom;
      endcase
      case ($urandom_range(3))
         0:       i.jump_target = '0;
         1:       i.jump_target = '1;
         default: i.jump_target = ADDR_FIELD_W'($urandom);
      endcase
      i.target_known = ($urandom_range(3) != 0);
      return i;
   endfunction

   // Offer one request, hold it until taken, then log its predicted outcome.
   task automatic send_request(instr_type i, logic fixed, logic [DATA_W-1:0] fixed_value,
                               logic fixed_div_error);
      outcome_type o;
      req_tvalid <= 1'b1;
      req_tuser  <= i.src_is_reg;
      req_tdata  <= {4'b0, i.target_known, i.jump_target, i.immediate,
                     i.src_reg, i.dest_reg, i.mode};
      do @(posedge clock); while (!req_tready);
      o = execute_alu(i);
      if (fixed) begin
         o = '{value: fixed_value, jump_taken: 1'b0, next_address: '0,
               div_error: fixed_div_error};
      end
      pending_outcomes.push_back(o);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every outstanding response is back.
   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value        = rsp_tdata[31:0];
            got.jump_taken   = rsp_tdata[32];
            got.next_address = rsp_tdata[48:33];
            got.div_error    = rsp_tdata[49];
            if (pending_outcomes.size() == 0) begin
               $error("response with no request outstanding: value %h", got.value);
               error_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (got.value !== want.value) begin
                  $error("value: expected %h, got %h", want.value, got.value);
                  error_count++;
               end
               if (got.jump_taken !== want.jump_taken) begin
                  $error("jump_taken: expected %b, got %b", want.jump_taken, got.jump_taken);
                  error_count++;
               end
               if (got.next_address !== want.next_address) begin
                  $error("next_address: expected %h, got %h",
                         want.next_address, got.next_address);
                  error_count++;
               end
               if (got.div_error !== want.div_error) begin
                  $error("div_error: expected %b, got %b", want.div_error, got.div_error);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int idle_pct [4];
      int stall_pct [4];
      idle_pct  = '{0, 67, 0, 17};
      stall_pct = '{0, 0, 67, 17};
      foreach (reg_shadow[k]) reg_shadow[k] = '0;
      flag_shadow = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 17;
      rsp_stall_pct  <= 17;
      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].instr, directed_rows[r].fixed,
                      directed_rows[r].fixed_value, directed_rows[r].fixed_div_error);
      end
      drain_pending();

      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_pct[ph];
         rsp_stall_pct  <= stall_pct[ph];
         for (int n = 0; n < RANDOM_PER_PH; n++) begin
            send_request(random_instr(), 1'b0, '0, 1'b0);
         end
         drain_pending();
      end

      // Allow time for any stray response to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rac_pkg.sv
hw/rtl/rac_front.sv
hw/rtl/rac_queue.sv
hw/rtl/rac_muldiv.sv
hw/rtl/rac_back.sv
hw/rtl/register_alu_compare_branch_top.sv
sim/register_alu_compare_branch_top_tb.sv
